// ----- rtl/mpe_pkg.sv -----
package mpe_pkg;

    localparam int MAX_PATTERN = 56;
    localparam int BOUND_MAX   = MAX_PATTERN - 2;
    localparam int NUM_CELLS   = MAX_PATTERN + 1;
    localparam int WIN_DEPTH   = MAX_PATTERN + 2;
    localparam int TEXT_BITS   = 8 * BOUND_MAX;
    localparam int WORD_COUNT  = (BOUND_MAX + 7) / 8;
    localparam int LAST_BITS   = TEXT_BITS - 64 * (WORD_COUNT - 1);

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef enum logic [7:0] {
        PH_SEEK   = 8'b0000_0001,
        PH_SKIP   = 8'b0000_0010,
        PH_SLASH  = 8'b0000_0100,
        PH_TYPE   = 8'b0000_1000,
        PH_HEADER = 8'b0001_0000,
        PH_LEAD   = 8'b0010_0000,
        PH_BODY   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_OPEN   = 3'd1,
        ST_NO_TYPE   = 3'd2,
        ST_NO_HEADER = 3'd3,
        ST_NO_CLOSE  = 3'd4,
        ST_SHORT     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_LENGTH = 3'd0,
        REG_WORD0  = 3'd1,
        REG_WORD1  = 3'd2,
        REG_WORD2  = 3'd3,
        REG_WORD3  = 3'd4,
        REG_WORD4  = 3'd5,
        REG_WORD5  = 3'd6,
        REG_WORD6  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [5:0]           boundary_length;
        logic [TEXT_BITS-1:0] boundary_text;
    } cfg_t;

    typedef struct packed {
        logic       shift;
        logic       search;
        logic [7:0] in_byte;
    } cell_ctrl_t;

endpackage

// ----- rtl/mpe_regs.sv -----
module mpe_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready,
    output mpe_pkg::cfg_t   cfg
);
    import mpe_pkg::*;

    logic [5:0]           length_reg;
    logic [TEXT_BITS-1:0] text_reg;
    logic                 write_en;
    reg_index_t           index;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign index    = reg_index_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= 6'd1;
            text_reg   <= '0;
        end
        else if (write_en)
        begin
            unique case (index)
                REG_LENGTH: length_reg <= pwdata[5:0];
                REG_WORD0:  text_reg[0 +: 64]   <= pwdata;
                REG_WORD1:  text_reg[64 +: 64]  <= pwdata;
                REG_WORD2:  text_reg[128 +: 64] <= pwdata;
                REG_WORD3:  text_reg[192 +: 64] <= pwdata;
                REG_WORD4:  text_reg[256 +: 64] <= pwdata;
                REG_WORD5:  text_reg[320 +: 64] <= pwdata;
                REG_WORD6:  text_reg[384 +: LAST_BITS] <= pwdata[LAST_BITS-1:0];
                default:    length_reg <= length_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_LENGTH: prdata = {58'd0, length_reg};
            REG_WORD0:  prdata = text_reg[0 +: 64];
            REG_WORD1:  prdata = text_reg[64 +: 64];
            REG_WORD2:  prdata = text_reg[128 +: 64];
            REG_WORD3:  prdata = text_reg[192 +: 64];
            REG_WORD4:  prdata = text_reg[256 +: 64];
            REG_WORD5:  prdata = text_reg[320 +: 64];
            REG_WORD6:  prdata = 64'(text_reg[384 +: LAST_BITS]);
            default:    prdata = '0;
        endcase
    end

    assign cfg.boundary_length = length_reg;
    assign cfg.boundary_text   = text_reg;

endmodule

// ----- rtl/mpe_cell.sv -----
module mpe_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mpe_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          pattern,
    input  logic                insert,
    input  logic                flag_in,
    input  logic [7:0]          data_in,
    output logic                hit,
    output logic                flag_out,
    output logic [7:0]          data_out
);
    import mpe_pkg::*;

    logic       flag_reg;
    logic       flag_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // A cell's flag says that the bytes ending at the newest one match the
    // pattern up to and including this cell's pattern byte.
    assign hit       = flag_in && (ctrl.in_byte == pattern);
    assign flag_next = ctrl.search ? hit : 1'b0;
    assign data_next = insert ? ctrl.in_byte : data_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= data_next;
        end
    end

    assign flag_out = flag_reg;
    assign data_out = data_reg;

endmodule

// ----- rtl/multipart_part_extractor.sv -----
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte, tlast last_byte
// m_axis    out        tuser[1:0] record_kind, tdata: out_byte, status,
//                      boundary_offset, content_length
// apb       in/out     8 registers of up to 64 bits at byte address 8*i
//
// One byte is taken in every cycle; the boundary compare runs through a row of
// cells in parallel, so a byte's result is ready in the cycle after its transfer.
// The result sits in an output register, and a new byte is taken whenever that
// register is empty or is being read in the same cycle.
// Reset clears the parse state and sets the boundary length to one.
module multipart_part_extractor #(
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] out_byte, [10:8] status,
                                   // [34:11] boundary_offset, [58:35] content_length
    output logic [1:0]  m_tuser,   // [1:0] record_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mpe_pkg::*;

    localparam int PB = POSITION_BITS;

    cfg_t       cfg;
    cell_ctrl_t ctrl;

    logic [NUM_CELLS-1:0] hit_vec;
    logic [NUM_CELLS-1:0] flag_vec;
    logic [7:0]           data_vec [NUM_CELLS];

    phase_t        phase_reg, phase_next, phase_step;
    logic [1:0]    skip_reg, skip_next;
    logic [5:0]    wcc_reg, wcc_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] cc_reg, cc_next;
    logic [7:0]    h1_reg, h2_reg, h3_reg;

    logic          out_valid_reg;
    kind_t         out_kind_reg;
    logic [7:0]    out_byte_reg;
    status_t       out_status_reg;
    logic [23:0]   out_off_reg;
    logic [23:0]   out_len_reg;

    logic          fire;
    logic          last;
    logic [7:0]    in_byte;
    logic [5:0]    bl_clamped;
    logic [5:0]    plen;
    logic [5:0]    plen_m1;
    logic [5:0]    thresh;
    logic          match;
    logic          search;
    logic [PB-1:0] pos_inc;
    logic [PB-1:0] offset;

    logic          emit;
    kind_t         emit_kind;
    logic [7:0]    emit_byte;
    status_t       emit_status;
    logic [23:0]   emit_off;
    logic [23:0]   emit_len;

    mpe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign last     = s_tlast;
    assign in_byte  = s_tdata;

    assign bl_clamped = (cfg.boundary_length > 6'(BOUND_MAX)) ? 6'(BOUND_MAX)
                                                              : cfg.boundary_length;
    assign plen    = bl_clamped + 6'd2;
    assign plen_m1 = plen - 6'd1;
    assign thresh  = plen + 6'd2;
    assign match   = hit_vec[plen_m1];

    assign ctrl.shift   = fire;
    assign ctrl.search  = search && !last;
    assign ctrl.in_byte = in_byte;

    genvar j;
    generate
        for (j = 0; j < NUM_CELLS; j++)
        begin : g_cell
            logic [7:0] pat;
            logic       flag_in;
            logic [7:0] data_in;

            if (j < 2)
            begin : g_dash
                assign pat = CHAR_DASH;
            end
            else if (j - 2 < BOUND_MAX)
            begin : g_text
                assign pat = cfg.boundary_text[8*(j-2) +: 8];
            end
            else
            begin : g_none
                assign pat = 8'h00;
            end

            if (j == 0)
            begin : g_head
                assign flag_in = 1'b1;
            end
            else
            begin : g_link
                assign flag_in = flag_vec[j-1];
            end

            if (j == NUM_CELLS - 1)
            begin : g_tail
                assign data_in = 8'h00;
            end
            else
            begin : g_next
                assign data_in = data_vec[j+1];
            end

            mpe_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .pattern  (pat),
                .insert   (plen == 6'(j)),
                .flag_in  (flag_in),
                .data_in  (data_in),
                .hit      (hit_vec[j]),
                .flag_out (flag_vec[j]),
                .data_out (data_vec[j])
            );
        end
    endgenerate

    assign pos_inc = pos_reg + 1'b1;
    assign offset  = pos_inc - PB'(plen);

    always_comb
    begin
        phase_step  = phase_reg;
        skip_next   = skip_reg;
        wcc_next    = wcc_reg;
        cc_next     = cc_reg;
        search      = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_TYPE;
        emit_byte   = 8'h00;
        emit_status = ST_OK;
        emit_off    = '0;
        emit_len    = '0;

        unique case (phase_reg)
            PH_SEEK:
            begin
                search = 1'b1;
                if (match)
                begin
                    phase_step = PH_SKIP;
                    skip_next  = 2'd2;
                end
            end
            PH_SKIP:
            begin
                if (skip_reg <= 2'd1)
                begin
                    skip_next  = 2'd0;
                    phase_step = PH_SLASH;
                end
                else
                begin
                    skip_next = skip_reg - 2'd1;
                end
            end
            PH_SLASH:
            begin
                if (in_byte == CHAR_SLASH)
                begin
                    phase_step = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (in_byte == CHAR_CR)
                begin
                    phase_step = PH_HEADER;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_TYPE;
                    emit_byte = in_byte;
                end
            end
            PH_HEADER:
            begin
                if (h3_reg == CHAR_CR && h2_reg == CHAR_LF &&
                    h1_reg == CHAR_CR && in_byte == CHAR_LF)
                begin
                    phase_step = PH_LEAD;
                    wcc_next   = 6'd0;
                    cc_next    = '0;
                end
            end
            PH_LEAD, PH_BODY:
            begin
                if (!(phase_reg == PH_LEAD &&
                      (in_byte == CHAR_CR || in_byte == CHAR_LF)))
                begin
                    search     = 1'b1;
                    phase_step = PH_BODY;
                    if (wcc_reg < 6'(WIN_DEPTH))
                    begin
                        wcc_next = wcc_reg + 6'd1;
                    end
                    if (match)
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_END;
                        phase_step = PH_DONE;
                        if (wcc_next >= thresh)
                        begin
                            emit_status = ST_OK;
                            emit_len    = 24'(cc_reg);
                        end
                        else
                        begin
                            emit_status = ST_SHORT;
                        end
                        emit_off = 24'(offset);
                    end
                    else if (wcc_next >= thresh)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_CONTENT;
                        emit_byte = data_vec[0];
                        cc_next   = cc_reg + 1'b1;
                    end
                end
            end
            PH_DONE:
            begin
                phase_step = PH_DONE;
            end
            default:
            begin
                phase_step = PH_SEEK;
            end
        endcase

        phase_next = phase_step;
        pos_next   = pos_inc;

        // The last byte of a message reports the current phase's error unless
        // the closing boundary has been seen, then starts a new message.
        if (last)
        begin
            if (phase_step != PH_DONE)
            begin
                emit      = 1'b1;
                emit_kind = KIND_END;
                emit_byte = 8'h00;
                emit_off  = '0;
                emit_len  = '0;
                unique case (phase_step)
                    PH_SEEK:                    emit_status = ST_NO_OPEN;
                    PH_SKIP, PH_SLASH, PH_TYPE: emit_status = ST_NO_TYPE;
                    PH_HEADER:                  emit_status = ST_NO_HEADER;
                    default:                    emit_status = ST_NO_CLOSE;
                endcase
            end
            phase_next = PH_SEEK;
            skip_next  = 2'd0;
            wcc_next   = 6'd0;
            pos_next   = '0;
            cc_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            skip_reg  <= 2'd0;
            wcc_reg   <= 6'd0;
            pos_reg   <= '0;
            cc_reg    <= '0;
            h1_reg    <= 8'h00;
            h2_reg    <= 8'h00;
            h3_reg    <= 8'h00;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            wcc_reg   <= wcc_next;
            pos_reg   <= pos_next;
            cc_reg    <= cc_next;
            h1_reg    <= last ? 8'h00 : in_byte;
            h2_reg    <= last ? 8'h00 : h1_reg;
            h3_reg    <= last ? 8'h00 : h2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_kind_reg   <= emit_kind;
            out_byte_reg   <= emit_byte;
            out_status_reg <= emit_status;
            out_off_reg    <= emit_off;
            out_len_reg    <= emit_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_off_reg, out_status_reg, out_byte_reg};

endmodule
